// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Transaction payloads, request codes and the bit-update unit interface.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BLOCK_W          = 15;
  localparam int KIND_W           = 1;
  localparam int CFG_W            = 4;
  localparam int SECTOR_BYTES     = 512;
  localparam int WORD_W           = 64;
  localparam int WORD_BYTES       = WORD_W / 8;
  localparam int WORDS_PER_SECTOR = SECTOR_BYTES / WORD_BYTES;
  localparam int POS_W            = $clog2(WORD_W);
  localparam int WSEC_W           = $clog2(WORDS_PER_SECTOR);
  localparam int INDEX_SECTORS    = 8;

  // Request codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] blk_num;
  } bba_in_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] result_index;
    logic               found;
  } bba_out_t;

  // Request to the bit-update unit
  typedef struct packed {
    logic [KIND_W-1:0] op;
    logic [POS_W-1:0]  bit_pos;
    logic              mask_low;
  } bba_upd_req_t;

  // Response of the bit-update unit
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } bba_upd_rsp_t;

endpackage

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/bba_update.sv =====
// ----------------------------------------------------------------------------
// bba_update: shared bit-update unit
// Find the lowest free bit of a bitmap word and set it, or clear a given bit.
// ----------------------------------------------------------------------------
module bba_update
  import bba_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  bba_upd_req_t      req,
  output bba_upd_rsp_t      rsp,
  output logic [WORD_W-1:0] new_word
);

  logic [WORD_BYTES-1:0] byte_full;
  logic [2:0]            sel_byte;
  logic [2:0]            sel_bit;
  logic [7:0]            sel_val;
  logic                  hit;

  // A byte counts as full when all its bits are set; byte 0 of a sector is
  // never handed out, so mask it as full.
  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      byte_full[i] = &word[i*8 +: 8];
    end
    if (req.mask_low) begin
      byte_full[0] = 1'b1;
    end
  end

  // Lowest byte with a free bit
  always_comb begin
    hit      = 1'b0;
    sel_byte = '0;
    for (int i = WORD_BYTES - 1; i >= 0; i--) begin
      if (!byte_full[i]) begin
        hit      = 1'b1;
        sel_byte = 3'(i);
      end
    end
  end

  assign sel_val = word[{sel_byte, 3'b000} +: 8];

  // Lowest zero bit inside that byte
  always_comb begin
    sel_bit = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!sel_val[j]) begin
        sel_bit = 3'(j);
      end
    end
  end

  assign rsp.hit = hit;
  assign rsp.pos = {sel_byte, sel_bit};

  always_comb begin
    case (req.op)
      KIND_FREE: new_word = word & ~(WORD_W'(1) << req.bit_pos);
      default:   new_word = word | (WORD_W'(1) << rsp.pos);
    endcase
  end

endmodule

// ===== design/bitmap_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top: free-space bitmap block allocator
// Allocate the first free block of the sectors in use, or free one block.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | handshake
//  --------+--------------------------------+----------------------------------
//  request | start, busy, in_data           | taken when start && !busy
//  result  | out_valid, out_data            | one-cycle strobe, never stalled
//  config  | cfg_valid, cfg_ready, cfg_data | write when cfg_valid && cfg_ready
//
//  Allocate: the bitmap word sequencer reads one 64-bit word per cycle from
//  the bitmap RAM and runs it through the shared bit-update unit; a hit is
//  answered through the registered RAM read data and the result register,
//  and a map with no free bit is reported after its last word is checked.
//  Free: one read-modify-write of a single word, none when rejected.
//  Reset: a clearing pass writes every RAM word to zero, one word a cycle,
//  with busy high; config is still taken.
//  The receiver cannot stall: each result shows for exactly one cycle.
//
module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int MAX_SECTORS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bba_in_t          in_data,
  output logic             out_valid,
  output bba_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // Only sectors 0 to 7 are reachable with a 15-bit block number
  localparam int EFF_SECTORS = (MAX_SECTORS < INDEX_SECTORS) ? MAX_SECTORS
                                                             : INDEX_SECTORS;
  localparam int DEPTH = EFF_SECTORS * WORDS_PER_SECTOR;
  localparam int AW    = $clog2(DEPTH);
  localparam int LIM_W = AW + 1;
  localparam logic [CFG_W-1:0] EFF_SEC = CFG_W'(EFF_SECTORS);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CLEAR   = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_FREE_RD = 5'b01000,
    ST_FREE_WR = 5'b10000
  } state_t;

  state_t             state_r,     state_nxt;
  logic [CFG_W-1:0]   used_r,      used_nxt;
  logic [LIM_W-1:0]   ptr_r,       ptr_nxt;
  logic               vld_r,       vld_nxt;
  logic [AW-1:0]      chk_addr_r,  chk_addr_nxt;
  logic [AW-1:0]      clr_ptr_r,   clr_ptr_nxt;
  logic [BLOCK_W-1:0] blk_r,       blk_nxt;
  logic               out_valid_r, out_valid_nxt;
  bba_out_t           out_data_r,  out_data_nxt;

  logic [CFG_W-1:0]   nsec;
  logic [LIM_W-1:0]   lim_words;
  logic               issue_en;
  logic               free_ok;
  logic [AW-1:0]      free_addr;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  bba_upd_req_t       upd_req;
  bba_upd_rsp_t       upd_rsp;
  logic [WORD_W-1:0]  upd_word;

  // Sectors actually scanned and accepted
  assign nsec      = (used_r > EFF_SEC) ? EFF_SEC : used_r;
  assign lim_words = LIM_W'({nsec, {WSEC_W{1'b0}}});
  assign issue_en  = (state_r == ST_SCAN) && (ptr_r < lim_words);

  // Free target: nonzero block inside the sectors in use
  assign free_ok   = (blk_r != '0) &&
                     ({1'b0, blk_r[BLOCK_W-1 -: 3]} < nsec);
  assign free_addr = blk_r[WSEC_W +: AW];

  assign ram_raddr = (state_r == ST_SCAN) ? ptr_r[AW-1:0] : free_addr;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Byte 0 of each sector is masked when the checked word opens a sector
  assign upd_req.op       = (state_r == ST_FREE_WR) ? KIND_FREE : KIND_ALLOC;
  assign upd_req.bit_pos  = blk_r[POS_W-1:0];
  assign upd_req.mask_low = (chk_addr_r[WSEC_W-1:0] == '0);

  bba_update u_update (
    .word     (ram_rdata),
    .req      (upd_req),
    .rsp      (upd_rsp),
    .new_word (upd_word)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    vld_nxt       = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    clr_ptr_nxt   = clr_ptr_r;
    blk_nxt       = blk_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = free_addr;
    ram_wdata     = upd_word;

    if (cfg_valid) begin
      used_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          blk_nxt = in_data.blk_num;
          ptr_nxt = '0;
          if (in_data.kind == KIND_FREE) begin
            state_nxt = ST_FREE_RD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        // Zero one word a cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_ptr_r;
        ram_wdata   = '0;
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Issue the next word read while checking the previous one
        vld_nxt      = issue_en;
        chk_addr_nxt = ptr_r[AW-1:0];
        if (issue_en) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (vld_r && upd_rsp.hit) begin
          ram_we                    = 1'b1;
          ram_waddr                 = chk_addr_r;
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_index = BLOCK_W'({chk_addr_r, upd_rsp.pos});
          out_data_nxt.found        = 1'b1;
          vld_nxt                   = 1'b0;
          state_nxt                 = ST_IDLE;
        end else if (!vld_r && !issue_en) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_index = '0;
          out_data_nxt.found        = 1'b0;
          state_nxt                 = ST_IDLE;
        end
      end
      ST_FREE_RD: begin
        if (free_ok) begin
          state_nxt = ST_FREE_WR;
        end else begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_index = '0;
          out_data_nxt.found        = 1'b0;
          state_nxt                 = ST_IDLE;
        end
      end
      ST_FREE_WR: begin
        ram_we                    = 1'b1;
        out_valid_nxt             = 1'b1;
        out_data_nxt.result_index = blk_r;
        out_data_nxt.found        = 1'b1;
        state_nxt                 = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      used_r      <= CFG_W'(1);
      ptr_r       <= '0;
      vld_r       <= 1'b0;
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ptr_r       <= ptr_nxt;
      vld_r       <= vld_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker: port-level checks of the bitmap block allocator
// Watch the request and result ports over time.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input bba_out_t out_data
);

  // An accepted transaction makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepted transaction");

  // Results never come back to back
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // A result follows work in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in progress");

  // A failed transaction reports block zero
  a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.result_index == '0))
    else $error("failed result with nonzero index");

  // Bitmap clearing runs right after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("block idle right after reset");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
